>>> design/pyp_pkg.sv
`default_nettype none
package pyp_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int SUM_W = 18;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_INDEXED = 2'd1,
    KIND_RGB     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Unscaled BT.601 sums, rounding and offsets already added.
  typedef struct packed {
    logic signed [SUM_W-1:0] y;
    logic signed [SUM_W-1:0] u;
    logic signed [SUM_W-1:0] v;
  } sums_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv_t;

  // Divide by 256 and clamp to 0..255. The sum never exceeds 17 bits.
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] s);
    logic [7:0] c;
    if (s[SUM_W-1]) begin
      c = 8'd0;
    end else if (s[16]) begin
      c = 8'hff;
    end else begin
      c = s[15:8];
    end
    return c;
  endfunction

  function automatic yuv_t to_yuv(input sums_t s);
    yuv_t p;
    p.y = clamp8(s.y);
    p.u = clamp8(s.u);
    p.v = clamp8(s.v);
    return p;
  endfunction

  function automatic logic [31:0] pack_pair(input yuv_t p0, input yuv_t p1);
    logic [8:0] u_sum;
    logic [8:0] v_sum;
    u_sum = {1'b0, p0.u} + {1'b0, p1.u} + 9'd1;
    v_sum = {1'b0, p0.v} + {1'b0, p1.v} + 9'd1;
    return {p0.y, u_sum[8:1], p1.y, v_sum[8:1]};
  endfunction

endpackage
`default_nettype wire

>>> design/pyp_if.sv
`default_nettype none
interface pyp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] index0;
  logic [7:0] index1;
  logic [7:0] red0;
  logic [7:0] green0;
  logic [7:0] blue0;
  logic [7:0] red1;
  logic [7:0] green1;
  logic [7:0] blue1;

  modport source (
    output valid, kind, index0, index1, red0, green0, blue0, red1, green1, blue1,
    input  ready
  );
  modport sink (
    input  valid, kind, index0, index1, red0, green0, blue0, red1, green1, blue1,
    output ready
  );
endinterface

interface pyp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] yuyv_word;
  logic        palette_missing;

  modport source (
    output valid, yuyv_word, palette_missing,
    input  ready
  );
  modport sink (
    input  valid, yuyv_word, palette_missing,
    output ready
  );
endinterface
`default_nettype wire

>>> design/pyp_ram.sv
`default_nettype none
module pyp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  // Read data holds when no read is requested; a read that hits the
  // address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata0_r <= mem_r[raddr0];
      rdata1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule
`default_nettype wire

>>> design/pyp_csc.sv
`default_nettype none
module pyp_csc (
  input  wire pyp_pkg::rgb_t  rgb,
  output pyp_pkg::sums_t      sums
);

  localparam int W = pyp_pkg::SUM_W;

  logic signed [W-1:0] r;
  logic signed [W-1:0] g;
  logic signed [W-1:0] b;

  assign r = $signed({{(W-8){1'b0}}, rgb.red});
  assign g = $signed({{(W-8){1'b0}}, rgb.green});
  assign b = $signed({{(W-8){1'b0}}, rgb.blue});

  // Offsets include the +128 rounding term ahead of the shift by 8.
  assign sums.y = W'(66) * r + W'(129) * g + W'(25) * b + W'(4096 + 128);
  assign sums.u = W'(112) * b - W'(38) * r - W'(74) * g + W'(32768 + 128);
  assign sums.v = W'(112) * r - W'(94) * g - W'(18) * b + W'(32768 + 128);

endmodule
`default_nettype wire

>>> design/palette_and_rgb_to_yuyv_packer_top.sv
// A result passes through the stage-1 register and then the output register.
// Throughput: one pixel pair or palette write per cycle, set by the dual-read palette RAM,
// while the output is not stalled; a result left untaken holds a following result in stage 1.
// A palette write in one cycle is forwarded to an indexed pair accepted in the next.
// Reset clears the pipeline and the palette-valid flag; palette contents are not cleared
// and no clearing pass runs, so the block accepts items as soon as reset is released.
`default_nettype none
module palette_and_rgb_to_yuyv_packer_top #(
  parameter int PALETTE_ENTRIES = pyp_pkg::PALETTE_ENTRIES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pyp_in_if.sink     in_chan,
  pyp_out_if.source  out_chan
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  // Stage 1: sums registered, palette read in flight.
  logic                 s1_valid_r;
  logic [1:0]           s1_kind_r;
  logic [7:0]           s1_idx0_r;
  logic                 s1_rng0_r;
  logic                 s1_rng1_r;
  logic                 s1_fwd0_r;
  logic                 s1_fwd1_r;
  pyp_pkg::sums_t       s1_sums0_r;
  pyp_pkg::sums_t       s1_sums1_r;
  pyp_pkg::yuv_t        fwd_data_r;
  logic                 pal_valid_r;

  logic                 out_valid_r;
  logic [31:0]          out_word_r;
  logic                 out_miss_r;

  pyp_pkg::sums_t       sums0;
  pyp_pkg::sums_t       sums1;
  logic                 in_accept;
  logic                 in_ready;
  logic                 s1_has_result;
  logic                 s1_go;
  logic                 ram_we;
  pyp_pkg::yuv_t        wr_data;
  logic [23:0]          rd0;
  logic [23:0]          rd1;
  pyp_pkg::yuv_t        pal0;
  pyp_pkg::yuv_t        pal1;
  logic [31:0]          word_nxt;
  logic                 miss_nxt;

  pyp_csc u_csc0 (
    .rgb  ({in_chan.red0, in_chan.green0, in_chan.blue0}),
    .sums (sums0)
  );

  pyp_csc u_csc1 (
    .rgb  ({in_chan.red1, in_chan.green1, in_chan.blue1}),
    .sums (sums1)
  );

  assign s1_has_result = (s1_kind_r == pyp_pkg::KIND_INDEXED) ||
                         (s1_kind_r == pyp_pkg::KIND_RGB);
  assign s1_go     = s1_valid_r && (!s1_has_result || !out_valid_r || out_chan.ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_accept = in_chan.valid && in_ready;

  assign wr_data = pyp_pkg::to_yuv(s1_sums0_r);
  assign ram_we  = s1_go && (s1_kind_r == pyp_pkg::KIND_WRITE) && s1_rng0_r;

  pyp_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s1_idx0_r[AW-1:0]),
    .wdata  (wr_data),
    .re     (in_accept),
    .raddr0 (in_chan.index0[AW-1:0]),
    .raddr1 (in_chan.index1[AW-1:0]),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  // A write in the same cycle as the read is not seen by the RAM, so the
  // new entry is taken from the forwarding register instead.
  always_comb begin
    if (!s1_rng0_r) begin
      pal0 = '0;
    end else if (s1_fwd0_r) begin
      pal0 = fwd_data_r;
    end else begin
      pal0 = rd0;
    end
    if (!s1_rng1_r) begin
      pal1 = '0;
    end else if (s1_fwd1_r) begin
      pal1 = fwd_data_r;
    end else begin
      pal1 = rd1;
    end
  end

  always_comb begin
    word_nxt = '0;
    miss_nxt = 1'b0;
    case (s1_kind_r)
      pyp_pkg::KIND_INDEXED: begin
        if (pal_valid_r) begin
          word_nxt = pyp_pkg::pack_pair(pal0, pal1);
        end else begin
          miss_nxt = 1'b1;
        end
      end
      pyp_pkg::KIND_RGB: begin
        word_nxt = pyp_pkg::pack_pair(pyp_pkg::to_yuv(s1_sums0_r),
                                      pyp_pkg::to_yuv(s1_sums1_r));
      end
      default: begin
        word_nxt = '0;
        miss_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pal_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go && s1_has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we && (s1_idx0_r == 8'(PALETTE_ENTRIES - 1))) begin
        pal_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r  <= in_chan.kind;
      s1_idx0_r  <= in_chan.index0;
      s1_rng0_r  <= {1'b0, in_chan.index0} < 9'(PALETTE_ENTRIES);
      s1_rng1_r  <= {1'b0, in_chan.index1} < 9'(PALETTE_ENTRIES);
      s1_fwd0_r  <= ram_we && (in_chan.index0 == s1_idx0_r);
      s1_fwd1_r  <= ram_we && (in_chan.index1 == s1_idx0_r);
      s1_sums0_r <= sums0;
      s1_sums1_r <= sums1;
    end
    if (ram_we) begin
      fwd_data_r <= wr_data;
    end
    if (s1_go && s1_has_result) begin
      out_word_r <= word_nxt;
      out_miss_r <= miss_nxt;
    end
  end

  assign in_chan.ready            = in_ready;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.yuyv_word       = out_word_r;
  assign out_chan.palette_missing = out_miss_r;

`ifndef ASSERT_OFF
  a_pal_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    pal_valid_r |=> pal_valid_r)
    else $error("palette valid flag dropped without reset");

  a_last_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && (s1_idx0_r == 8'(PALETTE_ENTRIES - 1)) |=> pal_valid_r)
    else $error("write to last palette entry did not set the valid flag");

  a_missing_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_miss_r |-> out_word_r == 32'd0)
    else $error("palette-missing result carries a nonzero word");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_has_result |-> !out_valid_r || out_chan.ready)
    else $error("pending result overwritten in the output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && s1_has_result)
    else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  typedef pyp_pkg::rgb_t rgb_t;
  typedef pyp_pkg::yuv_t yuv_t;

  localparam pyp_pkg::kind_t KIND_WRITE   = pyp_pkg::KIND_WRITE;
  localparam pyp_pkg::kind_t KIND_INDEXED = pyp_pkg::KIND_INDEXED;
  localparam pyp_pkg::kind_t KIND_RGB     = pyp_pkg::KIND_RGB;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam rgb_t RGB_BLACK   = 24'h000000;
  localparam rgb_t COLOR_WHITE = 24'hffffff;
  localparam rgb_t COLOR_RED   = 24'hff0000;
  localparam rgb_t COLOR_GREEN = 24'h00ff00;
  localparam rgb_t COLOR_BLUE  = 24'h0000ff;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] index0;
    logic [7:0] index1;
    rgb_t       px0;
    rgb_t       px1;
  } pair_request_t;

  typedef struct {
    logic [31:0] word;
    logic        missing;
  } packed_word_t;

  logic clk;
  logic rst_n;

  pyp_in_if  in_chan ();
  pyp_out_if out_chan ();

  palette_and_rgb_to_yuyv_packer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow palette and the words still owed by the block.
  yuv_t         palette_yuv [256];
  bit           palette_written [256];
  bit           palette_loaded;
  packed_word_t expected_words [$];

  bit sender_gaps;
  bit receiver_gaps;
  bit hold_off_request;
  int stall_left;
  int hold_left;
  int check_failures;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [7:0] limit_channel(input int s);
    if (s < 0) return 8'd0;
    if (s / 256 > 255) return 8'hff;
    return 8'(s / 256);
  endfunction

  function automatic yuv_t bt601_convert(input rgb_t c);
    int r, g, b;
    yuv_t p;
    r = c.red;
    g = c.green;
    b = c.blue;
    p.y = limit_channel(66 * r + 129 * g + 25 * b + 4096 + 128);
    p.u = limit_channel(-38 * r - 74 * g + 112 * b + 32768 + 128);
    p.v = limit_channel(112 * r - 94 * g - 18 * b + 32768 + 128);
    return p;
  endfunction

  function automatic logic [31:0] pair_word(input yuv_t a, input yuv_t b);
    int u_avg, v_avg;
    u_avg = (int'(a.u) + int'(b.u) + 1) >> 1;
    v_avg = (int'(a.v) + int'(b.v) + 1) >> 1;
    return {a.y, 8'(u_avg), b.y, 8'(v_avg)};
  endfunction

  function automatic void predict_yuyv(input pair_request_t it);
    packed_word_t w;
    case (it.kind)
      KIND_WRITE: begin
        palette_yuv[it.index0] = bt601_convert(it.px0);
        palette_written[it.index0] = 1'b1;
        if (it.index0 == 8'hff) palette_loaded = 1'b1;
      end
      KIND_INDEXED: begin
        if (palette_loaded) begin
          w.word = pair_word(palette_yuv[it.index0], palette_yuv[it.index1]);
          w.missing = 1'b0;
        end else begin
          w.word = 32'd0;
          w.missing = 1'b1;
        end
        expected_words.push_back(w);
      end
      KIND_RGB: begin
        w.word = pair_word(bt601_convert(it.px0), bt601_convert(it.px1));
        w.missing = 1'b0;
        expected_words.push_back(w);
      end
      default: ;
    endcase
  endfunction

  function automatic pair_request_t make_item(input logic [1:0] kind, input logic [7:0] i0,
                                             input logic [7:0] i1, input rgb_t a, input rgb_t b);
    pair_request_t it;
    it.kind = kind;
    it.index0 = i0;
    it.index1 = i1;
    it.px0 = a;
    it.px1 = b;
    return it;
  endfunction

  function automatic rgb_t random_colour();
    rgb_t c;
    c = 24'($urandom);
    // Now and then push every channel to an extreme.
    if ($urandom_range(0, 9) == 0) begin
      c.red = {8{c.red[0]}};
      c.green = {8{c.green[0]}};
      c.blue = {8{c.blue[0]}};
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_written_index();
    logic [7:0] idx;
    idx = 8'($urandom);
    while (!palette_written[idx]) idx = 8'($urandom);
    return idx;
  endfunction

  function automatic pair_request_t random_item();
    pair_request_t it;
    int pick;
    it = make_item(2'($urandom), 8'($urandom), 8'($urandom), random_colour(), random_colour());
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.kind = KIND_WRITE;
    end else if (pick < 62) begin
      it.kind = KIND_INDEXED;
      if (palette_loaded) begin
        it.index0 = pick_written_index();
        it.index1 = pick_written_index();
      end
    end else if (pick < 96) begin
      it.kind = KIND_RGB;
    end else begin
      it.kind = KIND_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input pair_request_t it);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.kind   <= it.kind;
    in_chan.index0 <= it.index0;
    in_chan.index1 <= it.index1;
    in_chan.red0   <= it.px0.red;
    in_chan.green0 <= it.px0.green;
    in_chan.blue0  <= it.px0.blue;
    in_chan.red1   <= it.px1.red;
    in_chan.green1 <= it.px1.green;
    in_chan.blue1  <= it.px1.blue;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_yuyv(it);
  endtask

  task automatic check_result();
    packed_word_t w;
    if (expected_words.size() == 0) begin
      $error("unexpected result: yuyv_word %h palette_missing %b",
             out_chan.yuyv_word, out_chan.palette_missing);
      check_failures++;
    end else begin
      w = expected_words.pop_front();
      if (out_chan.yuyv_word !== w.word) begin
        $error("yuyv_word: expected %h, got %h", w.word, out_chan.yuyv_word);
        check_failures++;
      end
      if (out_chan.palette_missing !== w.missing) begin
        $error("palette_missing: expected %b, got %b", w.missing, out_chan.palette_missing);
        check_failures++;
      end
    end
  endtask

  // Receiver: checks each transaction and decides ready for the next cycle.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) check_result();
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Indexed pairs before the palette is loaded, unused kind, and direct RGB extremes.
  task automatic test_unloaded_palette();
    send_item(make_item(KIND_INDEXED, 8'd0, 8'd0, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'hff, 8'hff, COLOR_WHITE, COLOR_WHITE));
    send_item(make_item(KIND_INDEXED, 8'($urandom), 8'($urandom), COLOR_RED, COLOR_BLUE));
    send_item(make_item(KIND_UNUSED, 8'hff, 8'hff, COLOR_WHITE, COLOR_WHITE));
    send_item(make_item(KIND_RGB, 8'd0, 8'd0, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_RGB, 8'hff, 8'hff, COLOR_WHITE, COLOR_WHITE));
    send_item(make_item(KIND_RGB, 8'd0, 8'd0, COLOR_RED, COLOR_GREEN));
    send_item(make_item(KIND_RGB, 8'd0, 8'd0, COLOR_BLUE, COLOR_WHITE));
    send_item(make_item(KIND_WRITE, 8'd0, 8'd0, COLOR_WHITE, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'd0, 8'd0, RGB_BLACK, RGB_BLACK));
  endtask

  // Loading the last entry, lookups at the extremes, and a write followed at once by a read.
  task automatic test_palette_lookup();
    send_item(make_item(KIND_WRITE, 8'd1, 8'd0, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_WRITE, 8'd254, 8'd0, COLOR_RED, RGB_BLACK));
    send_item(make_item(KIND_WRITE, 8'hff, 8'hff, COLOR_BLUE, COLOR_WHITE));
    send_item(make_item(KIND_INDEXED, 8'd0, 8'hff, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'hff, 8'd0, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'd1, 8'd254, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_WRITE, 8'd9, 8'd0, COLOR_GREEN, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'd9, 8'd9, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_WRITE, 8'd9, 8'd0, COLOR_WHITE, RGB_BLACK));
    send_item(make_item(KIND_INDEXED, 8'd9, 8'd1, RGB_BLACK, RGB_BLACK));
    send_item(make_item(KIND_UNUSED, 8'hff, 8'd9, COLOR_WHITE, COLOR_WHITE));
    send_item(make_item(KIND_RGB, 8'd0, 8'd0, COLOR_GREEN, COLOR_RED));
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_item(random_item());
  endtask

  // Rewrites every entry, then reads across the whole palette.
  task automatic test_palette_sweep();
    for (int i = 0; i < 256; i++) begin
      send_item(make_item(KIND_WRITE, 8'(i), 8'($urandom), random_colour(), random_colour()));
    end
    repeat (100) begin
      send_item(make_item(KIND_INDEXED, 8'($urandom), 8'($urandom), random_colour(),
                          random_colour()));
    end
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    hold_off_request = 1'b1;
    repeat (60) send_item(random_item());
    sender_gaps = 1'b1;
  endtask

  task automatic test_full_rate_stream();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    repeat (200) send_item(random_item());
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.kind   <= KIND_WRITE;
    in_chan.index0 <= 8'd0;
    in_chan.index1 <= 8'd0;
    in_chan.red0   <= 8'd0;
    in_chan.green0 <= 8'd0;
    in_chan.blue0  <= 8'd0;
    in_chan.red1   <= 8'd0;
    in_chan.green1 <= 8'd0;
    in_chan.blue1  <= 8'd0;
    palette_loaded = 1'b0;
    sender_gaps = 1'b0;
    receiver_gaps = 1'b1;
    hold_off_request = 1'b0;
    stall_left = 0;
    hold_left = 0;
    check_failures = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_unloaded_palette();
    test_palette_lookup();
    sender_gaps = 1'b1;
    test_random_mix(700);
    test_output_backpressure();
    test_palette_sweep();
    test_random_mix(600);
    test_full_rate_stream();

    in_chan.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
